// ===== rtl/elv_pkg.sv =====
// Package for the env line validator: result codes, character constants,
// counter widths and the structs passed between the validator modules.
// No dependencies.
package elv_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int OUT_FIELDS_W = 5 + 3 * COUNT_WIDTH;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_EQUALS    = 8'h3D;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [3:0] {
    STATUS_OK          = 4'd0,
    STATUS_BLANK       = 4'd1,
    STATUS_COMMENT     = 4'd2,
    STATUS_NO_EQUALS   = 4'd3,
    STATUS_KEY_LEAD_WS = 4'd4,
    STATUS_KEY_TRAIL_WS = 4'd5,
    STATUS_VAL_LEAD_WS = 4'd6,
    STATUS_BAD_KEY     = 4'd7,
    STATUS_OPEN_DOUBLE = 4'd8,
    STATUS_OPEN_SINGLE = 4'd9,
    STATUS_TRAILING    = 4'd10,
    STATUS_BAD_VALUE   = 4'd11
  } status_t;

  typedef struct packed {
    status_t status;
    logic    warn;
  } verdict_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] warnings;
    logic [COUNT_WIDTH-1:0] errors;
    logic [COUNT_WIDTH-1:0] checked;
  } totals_t;

endpackage

// ===== rtl/elv_flags.sv =====
// Per-line flag tracker: updates the line, key and value flags with each
// character and gives the verdict for the line as it would end here.
// Depends on elv_pkg.
module elv_flags
  import elv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       has_char,
  input  logic       line_end,
  output verdict_t   verdict
);

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_t;

  typedef struct packed {
    logic any;
    logic allsp;
    logic hash;
    logic eq;
  } line_t;

  typedef struct packed {
    logic nz;
    logic fws;
    logic lws;
    logic bad;
    logic low;
  } key_t;

  typedef struct packed {
    logic   nz;
    logic   fws;
    quote_t quote;
    logic   closed;
    logic   trail;
    logic   bad;
  } value_t;

  localparam line_t  LINE_CLEAR  = '{any: 1'b0, allsp: 1'b1, hash: 1'b0, eq: 1'b0};
  localparam key_t   KEY_CLEAR   = '0;
  localparam value_t VALUE_CLEAR = '{nz: 1'b0, fws: 1'b0, quote: QUOTE_NONE,
                                     closed: 1'b0, trail: 1'b0, bad: 1'b0};

  line_t  line, line_next;
  key_t   key, key_next;
  value_t value, value_next;

  logic is_sp, is_up, is_lo, is_dig, key_first_ok, key_next_ok, val_bad;
  logic [7:0] close_ch;

  assign is_sp = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
  assign is_up = (ch >= 8'h41) && (ch <= 8'h5A);
  assign is_lo = (ch >= 8'h61) && (ch <= 8'h7A);
  assign is_dig = (ch >= 8'h30) && (ch <= 8'h39);
  assign key_first_ok = is_up || is_lo || (ch == CH_UNDERLINE);
  assign key_next_ok = key_first_ok || is_dig;
  assign val_bad = is_sp || (ch == CH_SQUOTE) || (ch == CH_DQUOTE) || (ch == CH_BACKSLASH);
  assign close_ch = (value.quote == QUOTE_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    line_next = line;
    key_next = key;
    value_next = value;
    if (has_char) begin
      if (!line.any && ch == CH_HASH) line_next.hash = 1'b1;
      line_next.any = 1'b1;
      if (!is_sp) line_next.allsp = 1'b0;
      if (!line.eq) begin
        if (ch == CH_EQUALS) begin
          line_next.eq = 1'b1;
        end else begin
          if (!key.nz) begin
            key_next.nz = 1'b1;
            if (is_sp) key_next.fws = 1'b1;
            if (!key_first_ok) key_next.bad = 1'b1;
          end else if (!key_next_ok) begin
            key_next.bad = 1'b1;
          end
          key_next.lws = is_sp;
          if (is_lo) key_next.low = 1'b1;
        end
      end else if (!value.nz) begin
        value_next.nz = 1'b1;
        if (is_sp) value_next.fws = 1'b1;
        if (ch == CH_DQUOTE) value_next.quote = QUOTE_DOUBLE;
        else if (ch == CH_SQUOTE) value_next.quote = QUOTE_SINGLE;
        else if (val_bad) value_next.bad = 1'b1;
      end else if (value.quote != QUOTE_NONE) begin
        if (value.closed) value_next.trail = 1'b1;
        else if (ch == close_ch) value_next.closed = 1'b1;
      end else if (val_bad) begin
        value_next.bad = 1'b1;
      end
    end
  end

  always_comb begin
    verdict.warn = 1'b0;
    if (line_next.allsp) begin
      verdict.status = STATUS_BLANK;
    end else if (line_next.hash) begin
      verdict.status = STATUS_COMMENT;
    end else if (!line_next.eq) begin
      verdict.status = STATUS_NO_EQUALS;
    end else if (key_next.nz && key_next.fws) begin
      verdict.status = STATUS_KEY_LEAD_WS;
    end else if (key_next.nz && key_next.lws) begin
      verdict.status = STATUS_KEY_TRAIL_WS;
    end else if (value_next.nz && value_next.fws) begin
      verdict.status = STATUS_VAL_LEAD_WS;
    end else if (!key_next.nz || key_next.bad) begin
      verdict.status = STATUS_BAD_KEY;
    end else begin
      verdict.warn = key_next.low;
      if (!value_next.nz) begin
        verdict.status = STATUS_OK;
      end else if (value_next.quote != QUOTE_NONE) begin
        if (!value_next.closed) begin
          verdict.status = (value_next.quote == QUOTE_DOUBLE) ? STATUS_OPEN_DOUBLE
                                                              : STATUS_OPEN_SINGLE;
        end else if (value_next.trail) begin
          verdict.status = STATUS_TRAILING;
        end else begin
          verdict.status = STATUS_OK;
        end
      end else if (value_next.bad) begin
        verdict.status = STATUS_BAD_VALUE;
      end else begin
        verdict.status = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line <= LINE_CLEAR;
      key <= KEY_CLEAR;
      value <= VALUE_CLEAR;
    end else if (step) begin
      if (line_end) begin
        line <= LINE_CLEAR;
        key <= KEY_CLEAR;
        value <= VALUE_CLEAR;
      end else begin
        line <= line_next;
        key <= key_next;
        value <= value_next;
      end
    end
  end

endmodule

// ===== rtl/elv_totals.sv =====
// Saturating running totals of checked lines, errors and warnings.
// Gives the totals including the line being ended. Depends on elv_pkg.
module elv_totals
  import elv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  verdict_t verdict,
  output totals_t  totals_next
);

  totals_t totals;
  logic    is_error, is_checked;

  assign is_error = (verdict.status != STATUS_OK) && (verdict.status != STATUS_BLANK) &&
                    (verdict.status != STATUS_COMMENT);
  assign is_checked = is_error || (verdict.status == STATUS_OK);

  always_comb begin
    totals_next = totals;
    if (is_checked && totals.checked != '1) totals_next.checked = totals.checked + 1'b1;
    if (is_error && totals.errors != '1) totals_next.errors = totals.errors + 1'b1;
    if (verdict.warn && totals.warnings != '1) totals_next.warnings = totals.warnings + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
    end else if (step) begin
      totals <= totals_next;
    end
  end

endmodule

// ===== rtl/env_line_validator.sv =====
// Top level of the env line validator: input register, flag tracker,
// totals and result register. Depends on elv_pkg, elv_flags, elv_totals.
//
// Usage: the s_axis channel carries one character of a KEY=VALUE line per
// request; tdata holds the character, tuser says whether it is valid, and
// tlast marks the request that ends the line (tuser low with tlast high
// ends the line without adding a character). For each line end the m_axis
// channel delivers one result with the status code, the lowercase warning
// and the three saturating running totals; other requests give no result.
// A line end goes through the input register and the result register to
// m_axis_tvalid. One request is taken every cycle while s_axis_tready is
// high; the character flags are updated in a single pass between them.
// Reset clears the line flags, the totals and both valid bits. When the
// receiver stalls, characters keep flowing until a second line end reaches
// the input register while a result is still waiting; s_axis_tready then
// drops until the waiting result is taken.
module env_line_validator
  import elv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // ch
  input  logic                   s_axis_tuser,  // has_char
  input  logic                   s_axis_tlast,  // line_end
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status[3:0], warn_lowercase, lines_checked, error_count, warning_count
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_has;
  logic       in_end;
  logic       step;

  verdict_t verdict;
  totals_t  totals_next;
  verdict_t out_verdict;
  totals_t  out_totals;

  assign step = in_valid && (!in_end || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch <= s_axis_tdata;
      in_has <= s_axis_tuser;
      in_end <= s_axis_tlast;
    end
  end

  elv_flags u_flags (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .ch       (in_ch),
    .has_char (in_has),
    .line_end (in_end),
    .verdict  (verdict)
  );

  elv_totals u_totals (
    .clk         (clk),
    .rst         (rst),
    .step        (step && in_end),
    .verdict     (verdict),
    .totals_next (totals_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step && in_end) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_end) begin
      out_verdict <= verdict;
      out_totals <= totals_next;
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_totals.warnings, out_totals.errors,
                         out_totals.checked, out_verdict.warn, out_verdict.status};

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && in_valid && in_end))
    else $error("input stalled without a waiting result");

  a_errors_not_above_checked: assert property (@(posedge clk) disable iff (rst)
    totals_next.errors <= totals_next.checked)
    else $error("error total exceeds checked total");

  a_warn_only_valid_key: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_verdict.warn) |->
      (out_verdict.status == STATUS_OK || out_verdict.status == STATUS_OPEN_DOUBLE ||
       out_verdict.status == STATUS_OPEN_SINGLE || out_verdict.status == STATUS_TRAILING ||
       out_verdict.status == STATUS_BAD_VALUE))
    else $error("lowercase warning on a line without a valid key");

  a_result_after_line_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(step && in_end))
    else $error("result raised without a line end");

endmodule

// ===== bench/env_line_validator_tb.sv =====
// Self-checking testbench for env_line_validator: streams KEY=VALUE lines one
// character per request and checks every line result against a local model.
// Depends on elv_pkg and env_line_validator.
`timescale 1ns / 100ps

module env_line_validator_tb;
  import elv_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CHARS = 1020;
  localparam int FULL_RATE_CHARS = 300;

  typedef enum logic [1:0] {
    QUOTE_NONE,
    QUOTE_DOUBLE,
    QUOTE_SINGLE
  } quote_kind_t;

  typedef struct packed {
    status_t       status;
    logic          warn;
    logic [CW-1:0] checked;
    logic [CW-1:0] errors;
    logic [CW-1:0] warnings;
  } line_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'h00;  // ch
  logic                   s_axis_tuser = 1'b0;   // has_char
  logic                   s_axis_tlast = 1'b0;   // line_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  // status[3:0], warn_lowercase, lines_checked, error_count, warning_count
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  env_line_validator u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Line state of the model.
  logic          any_seen = 1'b0;
  logic          only_space = 1'b1;
  logic          first_hash = 1'b0;
  logic          eq_seen = 1'b0;
  logic          key_nz = 1'b0;
  logic          key_fws = 1'b0;
  logic          key_lws = 1'b0;
  logic          key_bad = 1'b0;
  logic          key_low = 1'b0;
  logic          val_nz = 1'b0;
  logic          val_fws = 1'b0;
  quote_kind_t   quote_kind = QUOTE_NONE;
  logic          val_closed = 1'b0;
  logic          val_trail = 1'b0;
  logic          val_bad = 1'b0;
  logic [CW-1:0] checked_total = '0;
  logic [CW-1:0] error_total = '0;
  logic [CW-1:0] warning_total = '0;

  line_result_t expected_results[$];
  logic [7:0]   line_bytes[$];

  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int stall_left = 0;
  int char_count = 0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_lower(logic [7:0] c);
    return c >= 8'h61 && c <= 8'h7A;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return is_lower(c) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit key_first_ok(logic [7:0] c);
    return is_letter(c) || c == CH_UNDERLINE;
  endfunction

  function automatic bit key_next_ok(logic [7:0] c);
    return key_first_ok(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic bit value_char_bad(logic [7:0] c);
    return is_space(c) || c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BACKSLASH;
  endfunction

  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'h09 + r[7:0];
  endfunction

  function automatic logic [7:0] pick_key_char(bit first);
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5 || (r == 9 && first)) begin
      return 8'h41 + 8'($urandom_range(0, 25));
    end else if (r <= 7) begin
      return 8'h61 + 8'($urandom_range(0, 25));
    end else if (r == 8) begin
      return CH_UNDERLINE;
    end
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_value_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(8'h21, 8'h7E));
    end while (value_char_bad(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_quoted_char(logic [7:0] closing);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == closing);
    return c;
  endfunction

  task automatic clear_line_state();
    any_seen = 1'b0;
    only_space = 1'b1;
    first_hash = 1'b0;
    eq_seen = 1'b0;
    key_nz = 1'b0;
    key_fws = 1'b0;
    key_lws = 1'b0;
    key_bad = 1'b0;
    key_low = 1'b0;
    val_nz = 1'b0;
    val_fws = 1'b0;
    quote_kind = QUOTE_NONE;
    val_closed = 1'b0;
    val_trail = 1'b0;
    val_bad = 1'b0;
  endtask

  // Applies one accepted request to the line state and, at a line end,
  // queues the verdict and running totals for that line.
  task automatic model_request(logic [7:0] c, logic has, logic last);
    line_result_t res;
    logic [7:0]   closing;
    if (has) begin
      if (!any_seen && c == CH_HASH) first_hash = 1'b1;
      any_seen = 1'b1;
      if (!is_space(c)) only_space = 1'b0;
      if (!eq_seen) begin
        if (c == CH_EQUALS) begin
          eq_seen = 1'b1;
        end else begin
          if (!key_nz) begin
            key_nz = 1'b1;
            if (is_space(c)) key_fws = 1'b1;
            if (!key_first_ok(c)) key_bad = 1'b1;
          end else if (!key_next_ok(c)) begin
            key_bad = 1'b1;
          end
          key_lws = is_space(c);
          if (is_lower(c)) key_low = 1'b1;
        end
      end else if (!val_nz) begin
        val_nz = 1'b1;
        if (is_space(c)) val_fws = 1'b1;
        if (c == CH_DQUOTE) quote_kind = QUOTE_DOUBLE;
        else if (c == CH_SQUOTE) quote_kind = QUOTE_SINGLE;
        else if (value_char_bad(c)) val_bad = 1'b1;
      end else if (quote_kind != QUOTE_NONE) begin
        closing = (quote_kind == QUOTE_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
        if (val_closed) val_trail = 1'b1;
        else if (c == closing) val_closed = 1'b1;
      end else if (value_char_bad(c)) begin
        val_bad = 1'b1;
      end
    end
    if (last) begin
      res = '0;
      if (only_space) res.status = STATUS_BLANK;
      else if (first_hash) res.status = STATUS_COMMENT;
      else if (!eq_seen) res.status = STATUS_NO_EQUALS;
      else if (key_nz && key_fws) res.status = STATUS_KEY_LEAD_WS;
      else if (key_nz && key_lws) res.status = STATUS_KEY_TRAIL_WS;
      else if (val_nz && val_fws) res.status = STATUS_VAL_LEAD_WS;
      else if (!key_nz || key_bad) res.status = STATUS_BAD_KEY;
      else begin
        res.warn = key_low;
        if (!val_nz) res.status = STATUS_OK;
        else if (quote_kind != QUOTE_NONE) begin
          if (!val_closed) begin
            res.status = (quote_kind == QUOTE_DOUBLE) ? STATUS_OPEN_DOUBLE : STATUS_OPEN_SINGLE;
          end else if (val_trail) begin
            res.status = STATUS_TRAILING;
          end else begin
            res.status = STATUS_OK;
          end
        end else if (val_bad) res.status = STATUS_BAD_VALUE;
        else res.status = STATUS_OK;
      end
      if ((res.status == STATUS_OK || res.status >= STATUS_NO_EQUALS) && checked_total != '1) begin
        checked_total = checked_total + 1'b1;
      end
      if (res.status >= STATUS_NO_EQUALS && error_total != '1) begin
        error_total = error_total + 1'b1;
      end
      if (res.warn && warning_total != '1) warning_total = warning_total + 1'b1;
      res.checked = checked_total;
      res.errors = error_total;
      res.warnings = warning_total;
      expected_results.push_back(res);
      clear_line_state();
    end
  endtask

  task automatic send_request(logic [7:0] c, logic has, logic last);
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= has;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    if (has) char_count++;
    model_request(c, has, last);
  endtask

  task automatic send_line(bit noops, bit end_marker);
    int i;
    if (line_bytes.size() == 0) begin
      send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      for (i = 0; i < line_bytes.size(); i++) begin
        if (noops && $urandom_range(0, 15) == 0) begin
          send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        send_request(line_bytes[i], 1'b1, (i == line_bytes.size() - 1) && !end_marker);
      end
      if (end_marker) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic send_text(string s);
    int i;
    line_bytes.delete();
    for (i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    send_line(1'b0, 1'b0);
  endtask

  task automatic build_kv_line();
    int         klen;
    int         vlen;
    int         style;
    int         i;
    logic [7:0] qc;
    line_bytes.delete();
    klen = $urandom_range(1, 6);
    for (i = 0; i < klen; i++) line_bytes.push_back(pick_key_char(i == 0));
    line_bytes.push_back(CH_EQUALS);
    style = $urandom_range(0, 3);
    vlen = $urandom_range(0, 6);
    if (style < 2) begin
      for (i = 0; i < vlen; i++) line_bytes.push_back(pick_value_char());
    end else begin
      qc = (style == 2) ? CH_DQUOTE : CH_SQUOTE;
      line_bytes.push_back(qc);
      for (i = 0; i < vlen; i++) line_bytes.push_back(pick_quoted_char(qc));
      if ($urandom_range(0, 5) != 0) line_bytes.push_back(qc);
      if ($urandom_range(0, 5) == 0) line_bytes.push_back(pick_value_char());
    end
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 6))
        0: line_bytes.push_front(pick_space());
        1: line_bytes.insert(klen, pick_space());
        2: line_bytes.insert(klen + 1, pick_space());
        3: line_bytes.delete(klen);
        4: line_bytes[0] = 8'h30 + 8'($urandom_range(0, 9));
        5: line_bytes[$urandom_range(0, klen - 1)] = 8'($urandom_range(0, 255));
        default: begin
          case ($urandom_range(0, 3))
            0: qc = pick_space();
            1: qc = CH_SQUOTE;
            2: qc = CH_DQUOTE;
            default: qc = CH_BACKSLASH;
          endcase
          line_bytes.insert($urandom_range(klen + 1, line_bytes.size()), qc);
        end
      endcase
    end
  endtask

  task automatic build_random_line();
    int kind;
    int n;
    int i;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      build_kv_line();
    end else begin
      line_bytes.delete();
      if (kind < 70) begin
        line_bytes.push_back(CH_HASH);
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 78) begin
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) line_bytes.push_back(pick_space());
      end else begin
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) line_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0) begin
          line_bytes.insert($urandom_range(0, line_bytes.size()), CH_EQUALS);
        end
      end
    end
  endtask

  task automatic test_directed_lines();
    send_text("");
    send_text("#");
    send_text("=");
    send_text(" A=");
    send_text("A =");
    send_text("A= ");
    send_text("a=\"");
    send_text("B='");
    send_text("c='\\'");
    send_text("A=''x");
    send_text("A==\\");
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(CH_EQUALS, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_lines();
    int target;
    target = char_count + RANDOM_CHARS;
    while (char_count < target) begin
      build_random_line();
      send_line(1'b1, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_full_rate_lines();
    int target;
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    target = char_count + FULL_RATE_CHARS;
    while (char_count < target) begin
      build_random_line();
      send_line(1'b1, $urandom_range(0, 7) == 0);
    end
  endtask

  always @(posedge clk) begin : result_check
    line_result_t got;
    line_result_t exp;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = status_t'(m_axis_tdata[3:0]);
      got.warn = m_axis_tdata[4];
      got.checked = m_axis_tdata[5 +: CW];
      got.errors = m_axis_tdata[5 + CW +: CW];
      got.warnings = m_axis_tdata[5 + 2 * CW +: CW];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: status %0d warn %0d checked %0d errors %0d warnings %0d",
                   got.status, got.warn, got.checked, got.errors, got.warnings);
        end
      end else begin
        exp = expected_results.pop_front();
        if (got.status != exp.status || got.warn != exp.warn || got.checked != exp.checked ||
            got.errors != exp.errors || got.warnings != exp.warnings) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected status %0d warn %0d checked %0d errors %0d warnings %0d",
                     exp.status, exp.warn, exp.checked, exp.errors, exp.warnings);
            $display("          actual   status %0d warn %0d checked %0d errors %0d warnings %0d",
                     got.status, got.warn, got.checked, got.errors, got.warnings);
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_lines();
    test_random_lines();
    test_full_rate_lines();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/elv_pkg.sv
rtl/elv_flags.sv
rtl/elv_totals.sv
rtl/env_line_validator.sv
bench/env_line_validator_tb.sv
